/* src/wtg_pkg.sv */
`timescale 1ns / 1ps
package wtg_pkg;

  localparam int PHASE_BITS = 32;
  localparam int TABLE_BITS = 10;
  localparam int INDEX_BITS = 24;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 24;
  localparam int STEP_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CMP_W    = (INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W;
  localparam int STATE_W  = INDEX_BITS + PHASE_BITS;

  localparam int QSIZE   = 1 << (TABLE_BITS - 2);
  localparam int QADDR_W = TABLE_BITS - 1;
  localparam int MAG_W   = 15;
  localparam logic [MAG_W-1:0] AMPL = 15'd32000;
  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2
  } wave_e;

  typedef enum logic [1:0] {
    REG_WAVEFORM     = 2'd0,
    REG_PHASE_STEP   = 2'd1,
    REG_SAMPLE_COUNT = 2'd2
  } cfg_reg_e;

  // phase stage to shaper
  typedef struct packed {
    logic                  valid;
    logic [PHASE_BITS-1:0] phase;
    logic                  last;
  } wtg_s2_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } wtg_res_t;

  typedef logic [MAG_W-1:0] qtab_t [QSIZE+1];

  // quarter sine point, Q30 taylor series through the x^15 term
  function automatic logic [MAG_W-1:0] sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned s;
    longint unsigned v;
    x    = (64'(k) * HALFPI_Q30) / QSIZE;
    x2   = (x * x) >> 30;
    pos  = x;
    neg  = 64'd0;
    term = ((x * x2) >> 30) / 64'd6;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd20;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd42;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd72;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd110;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd156;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd210;
    neg  = neg + term;
    s = (pos > neg) ? (pos - neg) : 64'd0;
    v = (s * 64'd32000 + (64'd1 << 29)) >> 30;
    if (v > 64'd32000) begin
      v = 64'd32000;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int unsigned k = 0; k <= QSIZE; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

/* src/wtg_ram.sv */
`timescale 1ns / 1ps
module wtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/wtg_phase.sv */
`timescale 1ns / 1ps
module wtg_phase import wtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_restart_i,
  input  logic [STEP_W-1:0]  phase_step_i,
  input  logic [COUNT_W-1:0] sample_count_i,
  output logic               s1_valid_o,
  output wtg_s2_t            s2_o
);

  logic                  s1_valid_q;
  logic                  s1_restart_q;
  logic                  written_q;
  logic                  rd_written_q;
  logic                  fwd_q;
  logic [STATE_W-1:0]    fwd_data_q;
  logic [STATE_W-1:0]    rdata;
  logic [STATE_W-1:0]    base;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [INDEX_BITS-1:0] cur_idx;
  logic [STATE_W-1:0]    next_state;
  logic                  cur_last;
  logic                  s2_valid_q;
  logic [PHASE_BITS-1:0] s2_phase_q;
  logic                  s2_last_q;

  // single-entry state store: {sample index, phase}
  wtg_ram #(
    .WIDTH(STATE_W),
    .DEPTH(1)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(1'b0),
    .wdata_i(next_state),
    .re_i   (req_valid_i),
    .raddr_i(1'b0),
    .rdata_o(rdata)
  );

  // write in the read cycle is not seen by the ram output: forward it
  always_comb begin
    if (fwd_q) begin
      base = fwd_data_q;
    end else if (rd_written_q) begin
      base = rdata;
    end else begin
      base = '0;
    end
    cur_phase  = s1_restart_q ? '0 : base[PHASE_BITS-1:0];
    cur_idx    = s1_restart_q ? '0 : base[STATE_W-1:PHASE_BITS];
    cur_last   = (sample_count_i != '0) &&
                 (CMP_W'(cur_idx) == CMP_W'(sample_count_i - COUNT_W'(1)));
    next_state = {cur_idx + INDEX_BITS'(1), cur_phase + PHASE_BITS'(phase_step_i)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      written_q    <= 1'b0;
      rd_written_q <= 1'b0;
      fwd_q        <= 1'b0;
    end else begin
      s1_valid_q   <= req_valid_i;
      s2_valid_q   <= s1_valid_q;
      rd_written_q <= written_q;
      fwd_q        <= s1_valid_q;
      if (s1_valid_q) begin
        written_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      s1_restart_q <= req_restart_i;
    end
    fwd_data_q <= next_state;
    s2_phase_q <= cur_phase;
    s2_last_q  <= cur_last;
  end

  assign s1_valid_o  = s1_valid_q;
  assign s2_o.valid  = s2_valid_q;
  assign s2_o.phase  = s2_phase_q;
  assign s2_o.last   = s2_last_q;

endmodule

/* src/wtg_shaper.sv */
`timescale 1ns / 1ps
module wtg_shaper import wtg_pkg::*; (
  input  wtg_s2_t  s2_i,
  input  wave_e    waveform_i,
  output wtg_res_t res_o
);

  logic [TABLE_BITS-1:0]       idx;
  logic [1:0]                  quad;
  logic [TABLE_BITS-3:0]       off;
  logic [QADDR_W-1:0]          qaddr;
  logic [MAG_W-1:0]            sine_mag;
  logic [PHASE_BITS:0]         twice;
  logic [PHASE_BITS:0]         full;
  logic [PHASE_BITS:0]         saw_m;
  logic [PHASE_BITS+MAG_W:0]   saw_prod;
  logic [MAG_W-1:0]            saw_mag;
  logic                        saw_neg;
  logic [SAMPLE_W-1:0]         sine_s;
  logic [SAMPLE_W-1:0]         saw_s;

  always_comb begin
    idx      = s2_i.phase[PHASE_BITS-1 -: TABLE_BITS];
    quad     = idx[TABLE_BITS-1:TABLE_BITS-2];
    off      = idx[TABLE_BITS-3:0];
    // mirror the quarter table on odd quadrants
    qaddr    = quad[0] ? (QADDR_W'(QSIZE) - QADDR_W'(off)) : QADDR_W'(off);
    sine_mag = QTAB[qaddr];
    sine_s   = quad[1] ? (SAMPLE_W'(0) - {1'b0, sine_mag}) : {1'b0, sine_mag};

    twice    = {s2_i.phase, 1'b0};
    full     = {1'b1, {PHASE_BITS{1'b0}}};
    saw_neg  = ~s2_i.phase[PHASE_BITS-1];
    saw_m    = saw_neg ? (full - twice) : (twice - full);
    saw_prod = (PHASE_BITS + MAG_W + 1)'(saw_m) * (PHASE_BITS + MAG_W + 1)'(AMPL);
    saw_mag  = saw_prod[PHASE_BITS +: MAG_W];
    saw_s    = saw_neg ? (SAMPLE_W'(0) - {1'b0, saw_mag}) : {1'b0, saw_mag};

    case (waveform_i)
      WAVE_SINE:   res_o.sample = sine_s;
      WAVE_SQUARE: res_o.sample = s2_i.phase[PHASE_BITS-1] ?
                                  (SAMPLE_W'(0) - {1'b0, AMPL}) : {1'b0, AMPL};
      WAVE_SAW:    res_o.sample = saw_s;
      default:     res_o.sample = '0;
    endcase
    res_o.last = s2_i.last;
  end

endmodule

/* src/wtg_out_fifo.sv */
`timescale 1ns / 1ps
module wtg_out_fifo import wtg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wtg_res_t              din_i,
  input  logic                  pop_i,
  output wtg_res_t              dout_o,
  output logic                  valid_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  wtg_res_t              buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q;
  logic [FIFO_PTR_W-1:0] rptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign dout_o  = buf_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= din_i;
    end
  end

endmodule

/* src/waveform_tone_generator_unit.sv */
`timescale 1ns / 1ps
// DDS tone generator: every request on the slave stream (bit 0 of tdata is restart) yields one
// signed 16-bit sample of a sine, square or sawtooth tone on the master stream, with tlast on
// the sample at index sample_count-1. One request per cycle is taken unless the input stalls;
// results pass stages s1, s2 and the output queue. The phase and sample index live in a
// one-entry memory that is read when a request arrives and written back the next cycle, with
// the write forwarded to a request that follows directly, which sets the one-sample-per-cycle
// rate. A four-entry output queue lets requests keep flowing while results wait; the input
// stalls once the queue and the two pipeline stages together hold four requests.
// Program waveform, phase_step and sample_count while the block is idle. No clearing pass.
module waveform_tone_generator_unit import wtg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] restart, [7:1] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  wave_e                 waveform_q;
  logic [STEP_W-1:0]     phase_step_q;
  logic [COUNT_W-1:0]    sample_count_q;
  logic                  req_acc;
  logic                  s1_valid;
  wtg_s2_t               s2;
  wtg_res_t              res;
  wtg_res_t              fifo_dout;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   in_flight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q     <= WAVE_SINE;
      phase_step_q   <= '0;
      sample_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WAVEFORM:     waveform_q     <= wave_e'(cfg_data_i[1:0]);
        REG_PHASE_STEP:   phase_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // reserve a queue slot for every request still in the pipe
  assign in_flight     = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(s1_valid) +
                         (FIFO_CNT_W + 1)'(s2.valid);
  assign s_axis_tready = (in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign req_acc       = s_axis_tvalid && s_axis_tready;

  wtg_phase u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_acc),
    .req_restart_i (s_axis_tdata[0]),
    .phase_step_i  (phase_step_q),
    .sample_count_i(sample_count_q),
    .s1_valid_o    (s1_valid),
    .s2_o          (s2)
  );

  wtg_shaper u_shaper (
    .s2_i      (s2),
    .waveform_i(waveform_q),
    .res_o     (res)
  );

  wtg_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s2.valid),
    .din_i  (res),
    .pop_i  (m_axis_tready),
    .dout_o (fifo_dout),
    .valid_o(m_axis_tvalid),
    .count_o(fifo_cnt)
  );

  assign m_axis_tdata = fifo_dout.sample;
  assign m_axis_tlast = fifo_dout.last;

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
    else $error("more requests in flight than output slots");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2.valid |-> (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || m_axis_tready)
    else $error("result pushed into full output queue");

  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && s_axis_tdata[0]) |-> ##2 (s2.valid && (s2.phase == '0)))
    else $error("restart did not clear the phase");
`endif

endmodule

/* sim/tb_waveform_tone_generator_unit.sv */
`timescale 1ns / 1ps

import wtg_pkg::*;

class tone_scoreboard;
  localparam int QUARTER = 256;
  localparam longint unsigned AMPLITUDE = 64'd32000;
  localparam longint unsigned HALF_PI = 64'd1686629713;

  int unsigned quarter_sine[QUARTER+1];
  logic [1:0]  wave;
  logic [31:0] step;
  logic [23:0] count;
  logic [31:0] phase;
  logic [23:0] index;
  wtg_res_t    expected_q[$];
  int          mismatches;

  function new();
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = sine_point(k);
    end
    wave       = WAVE_SINE;
    step       = '0;
    count      = '0;
    phase      = '0;
    index      = '0;
    mismatches = 0;
  endfunction

  // taylor series in Q30, terms up to x^15
  function int unsigned sine_point(int unsigned k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    longint unsigned mag;
    ang    = (longint'(k) * HALF_PI) / QUARTER;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    plus   = ang;
    minus  = 0;
    for (int n = 1; n <= 7; n++) begin
      term = (term * ang_sq) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        minus += term;
      end else begin
        plus += term;
      end
    end
    mag = (plus > minus) ? plus - minus : 0;
    mag = (mag * AMPLITUDE + (64'd1 << 29)) >> 30;
    if (mag > AMPLITUDE) begin
      mag = AMPLITUDE;
    end
    return int'(mag);
  endfunction

  function void set_reg(cfg_reg_e reg_idx, logic [31:0] value);
    case (reg_idx)
      REG_WAVEFORM:     wave  = value[1:0];
      REG_PHASE_STEP:   step  = value;
      REG_SAMPLE_COUNT: count = value[23:0];
      default: ;
    endcase
  endfunction

  function int wave_value();
    logic [9:0]      point;
    int              mag;
    longint unsigned twice;
    longint unsigned span;
    case (wave)
      WAVE_SINE: begin
        point = phase[31:22];
        mag = point[8] ? quarter_sine[QUARTER - point[7:0]] : quarter_sine[point[7:0]];
        return point[9] ? -mag : mag;
      end
      WAVE_SQUARE: return phase[31] ? -32000 : 32000;
      WAVE_SAW: begin
        twice = longint'(phase) << 1;
        span  = phase[31] ? twice - (64'd1 << 32) : (64'd1 << 32) - twice;
        mag   = int'((span * AMPLITUDE) >> 32);
        return phase[31] ? mag : -mag;
      end
      default: return 0;
    endcase
  endfunction

  function void note_request(bit restart);
    wtg_res_t res;
    int       value;
    if (restart) begin
      phase = '0;
      index = '0;
    end
    value      = wave_value();
    res.sample = value[15:0];
    res.last   = (count != 0) && (index == count - 24'd1);
    expected_q.push_back(res);
    phase = phase + step;
    index = index + 24'd1;
  endfunction

  function void check_sample(logic [15:0] sample, logic last);
    wtg_res_t exp_res;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected sample %0d last %0b", $signed(sample), last);
      end
      return;
    end
    exp_res = expected_q.pop_front();
    if (sample !== exp_res.sample || last !== exp_res.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("sample mismatch: exp %0d last %0b, got %0d last %0b",
                 $signed(exp_res.sample), exp_res.last, $signed(sample), last);
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_waveform_tone_generator_unit;
  localparam int LONG_HOLD = 60;
  localparam int LIMIT     = 200000;
  localparam logic [1:0] WAVE_SPARE = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  tone_scoreboard sb;
  bit  idle_on;
  bit  hold_req;
  int  cycles;

  waveform_tone_generator_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_request(s_axis_tdata[0]);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_sample(m_axis_tdata, m_axis_tlast);
    end
  end

  // sample sink: short random stalls, plus one long hold when asked
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready = 1'b0;
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        m_axis_tready = 1'b1;
        hold = 1;
      end
      repeat (hold) @(negedge clk_i);
    end
  end

  task automatic send_request(input bit restart);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_samples();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(input cfg_reg_e reg_idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = reg_idx;
    cfg_data_i = value;
    sb.set_reg(reg_idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic program_tone(input logic [1:0] wave, input logic [31:0] step,
                              input logic [23:0] count);
    program_reg(REG_WAVEFORM, {30'd0, wave});
    program_reg(REG_PHASE_STEP, step);
    program_reg(REG_SAMPLE_COUNT, {8'd0, count});
  endtask

  // random tone settings, then back-to-back tones that each begin with a restart
  task automatic run_tones(input int n_items, input int hold_at);
    logic [1:0]  wave;
    logic [31:0] step;
    logic [23:0] count;
    int          sent;
    int          len;
    wave = ($urandom_range(0, 7) == 0) ? WAVE_SPARE : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: step = 32'($urandom_range(1, 1 << 20));
      1: step = 32'hffff_ffff - 32'($urandom_range(0, 1 << 20));
      2: step = 32'd1 << $urandom_range(20, 31);
      3: step = '0;
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: count = '0;
      1: count = 24'hff_ffff;
      2: count = 24'($urandom);
      default: count = 24'($urandom_range(1, 40));
    endcase
    program_tone(wave, step, count);
    sent = 0;
    while (sent < n_items) begin
      if (count != 0 && count <= 64) begin
        len = count + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      end else begin
        len = $urandom_range(1, 60);
      end
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_request((k == 0) ? 1'b1 : ($urandom_range(0, 31) == 0));
        sent++;
        if (sent == hold_at) begin
          hold_req = 1'b1;
        end
      end
    end
    drain_samples();
  endtask

  initial begin
    sb            = new();
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WAVEFORM;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // registers at reset: flat sine, no last with a zero count
    send_request(1'b0);
    send_request(1'b0);
    drain_samples();

    // quarter-cycle steps hit the table ends in all four quadrants, then run past the end
    program_tone(WAVE_SINE, 32'h4000_0000, 24'd4);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    drain_samples();

    // square at half-cycle steps, single-sample tone
    program_tone(WAVE_SQUARE, 32'h8000_0000, 24'd1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    drain_samples();

    // sawtooth with the largest step wraps the phase every sample
    program_tone(WAVE_SAW, 32'hffff_ffff, 24'd3);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_samples();

    program_tone(WAVE_SAW, 32'h4000_0000, 24'hff_ffff);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_samples();

    // unused waveform code gives a silent sample
    program_tone(WAVE_SPARE, 32'h1234_5678, 24'd2);
    send_request(1'b1);
    send_request(1'b0);
    drain_samples();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        idle_on = 1'b0;
      end
      run_tones(200, (p == 2) ? 30 : 0);
    end

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* waveform_tone_generator_unit.f */
src/wtg_pkg.sv
src/wtg_ram.sv
src/wtg_phase.sv
src/wtg_shaper.sv
src/wtg_out_fifo.sv
src/waveform_tone_generator_unit.sv
sim/tb_waveform_tone_generator_unit.sv
